// ----- hw/rtl/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// shared constants and register map of the disparity to point core
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int PIXEL_INDEX_BITS_DEF = 12;

  localparam int DISP_W  = 16;
  localparam int MAP_W   = 20;
  localparam int FOCAL_W = 20;
  localparam int BASE_W  = 24;
  localparam int COORD_W = 21;
  localparam int BOX_W   = 63;
  localparam int COLOR_W = 8;
  localparam int RGB_W   = 24;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  // depth quotient and its numerator after the fixed shift
  localparam int NUM_W  = FOCAL_W + BASE_W;
  localparam int ZQ_W   = NUM_W - 8;

  localparam logic [COORD_W-1:0] SAT_POS = 21'h0FFFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 21'h100000;

  localparam logic [FOCAL_W-1:0] FOCAL_RST = 20'd256;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_FOCAL_X  = 3'd1,
    REG_FOCAL_Y  = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4,
    REG_BASELINE = 3'd5,
    REG_BOX_LOW  = 3'd6,
    REG_BOX_HIGH = 3'd7
  } cfg_reg_t;

endpackage

// ----- hw/rtl/dtp_divider.sv -----
// ----------------------------------------------------------------------------
// dtp_divider
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module dtp_divider #(
  parameter int QW = 36,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] work_r [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] work_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_rem;
      assign work_i = in_num;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign work_i = work_r[i-1];
      assign den_i  = den_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign trial = {rem_i, work_i[QW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        work_r[i] <= {work_i[QW-2:0], ge};
        den_r[i]  <= den_i;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = work_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- hw/rtl/disparity_to_point_core.sv -----
// ----------------------------------------------------------------------------
// disparity_to_point_core
// one stereo pixel in, one colored, box-filtered 3-d point out (or none)
// ----------------------------------------------------------------------------
// stages: 1 input, 36 depth divider steps, 3 multiply and range stages,
//   21 coordinate divider steps, 1 output register
// throughput: one beat per cycle; the whole pipe holds only while the
//   output register is full and stalled
// reset: pipe valid bits and output valid clear, registers take their
//   reset values (focal lengths 256, the rest 0)
module disparity_to_point_core #(
  parameter int PIXEL_INDEX_BITS = dtp_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PIXEL_INDEX_BITS-1:0]         in_pixel_x,
  input  logic [PIXEL_INDEX_BITS-1:0]         in_pixel_y,
  input  logic signed [dtp_pkg::DISP_W-1:0]   in_disparity_raw,
  input  logic [dtp_pkg::MAP_W-1:0]           in_map_x_here,
  input  logic [dtp_pkg::MAP_W-1:0]           in_map_x_shifted,
  input  logic [dtp_pkg::MAP_W-1:0]           in_map_y_here,
  input  logic [dtp_pkg::COLOR_W-1:0]         in_color_blue,
  input  logic [dtp_pkg::COLOR_W-1:0]         in_color_green,
  input  logic [dtp_pkg::COLOR_W-1:0]         in_color_red,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dtp_pkg::COORD_W-1:0]  out_point_x,
  output logic signed [dtp_pkg::COORD_W-1:0]  out_point_y,
  output logic signed [dtp_pkg::COORD_W-1:0]  out_point_z,
  output logic [dtp_pkg::RGB_W-1:0]           out_color_rgb,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtp_pkg::CFG_AW-1:0]          paddr,
  input  logic [dtp_pkg::CFG_DW-1:0]          pwdata,
  output logic [dtp_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  import dtp_pkg::*;

  localparam int PIB = PIXEL_INDEX_BITS;
  localparam int UW  = (PIB + 8 > MAP_W) ? PIB + 8 : MAP_W;
  localparam int CW  = (PIB + 5 > DISP_W + 1) ? PIB + 5 : DISP_W + 1;
  localparam int HW  = ZQ_W / 2;
  localparam int PPW = HW + UW;
  localparam int PW  = ZQ_W + UW;
  localparam int OW  = FOCAL_W + COORD_W;

  typedef struct packed {
    logic          ok;
    logic          sx;
    logic [UW-1:0] magx;
    logic          sy;
    logic [UW-1:0] magy;
    logic [RGB_W-1:0] rgb;
  } z_side_t;

  typedef struct packed {
    logic               ok;
    logic               sx;
    logic               ovf;
    logic [COORD_W-1:0] z;
    logic [RGB_W-1:0]   rgb;
  } x_side_t;

  typedef struct packed {
    logic sy;
    logic ovf;
  } y_side_t;

  // configuration registers
  logic               mode_r;
  logic [FOCAL_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [BASE_W-1:0]  baseline_r;
  logic [BOX_W-1:0]   box_low_r, box_high_r;
  logic [NUM_W-1:0]   num_r;
  logic               wr_en;
  cfg_reg_t           wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = cfg_reg_t'(paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      focal_x_r  <= FOCAL_RST;
      focal_y_r  <= FOCAL_RST;
      center_x_r <= '0;
      center_y_r <= '0;
      baseline_r <= '0;
      box_low_r  <= '0;
      box_high_r <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_MODE:     mode_r     <= pwdata[0];
        REG_FOCAL_X:  focal_x_r  <= pwdata[FOCAL_W-1:0];
        REG_FOCAL_Y:  focal_y_r  <= pwdata[FOCAL_W-1:0];
        REG_CENTER_X: center_x_r <= pwdata[FOCAL_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[FOCAL_W-1:0];
        REG_BASELINE: baseline_r <= pwdata[BASE_W-1:0];
        REG_BOX_LOW:  box_low_r  <= pwdata[BOX_W-1:0];
        REG_BOX_HIGH: box_high_r <= pwdata[BOX_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      REG_MODE:     prdata = CFG_DW'(mode_r);
      REG_FOCAL_X:  prdata = CFG_DW'(focal_x_r);
      REG_FOCAL_Y:  prdata = CFG_DW'(focal_y_r);
      REG_CENTER_X: prdata = CFG_DW'(center_x_r);
      REG_CENTER_Y: prdata = CFG_DW'(center_y_r);
      REG_BASELINE: prdata = CFG_DW'(baseline_r);
      REG_BOX_LOW:  prdata = CFG_DW'(box_low_r);
      REG_BOX_HIGH: prdata = CFG_DW'(box_high_r);
    endcase
  end

  always_ff @(posedge clk) begin
    num_r <= NUM_W'(focal_x_r) * NUM_W'(baseline_r);
  end

  // pipe advance
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: checks, divisor, offsets
  logic signed [CW-1:0] raw_ext, lim;
  logic                 fish_bad, raw_pos, dm_pos, ok_nxt;
  logic [MAP_W:0]       dm;
  logic [UW-1:0]        u, v;
  logic [UW:0]          dx, dy;
  logic [FOCAL_W-1:0]   den_nxt;
  z_side_t              zs_nxt, zs_r;
  logic [FOCAL_W-1:0]   den_r;
  logic                 v1_r, fish1_r;

  always_comb begin
    raw_ext  = {{(CW-DISP_W){in_disparity_raw[DISP_W-1]}}, in_disparity_raw};
    lim      = {{(CW-PIB-4){1'b0}}, in_pixel_x, 4'b0};
    fish_bad = (in_disparity_raw < 16) || (raw_ext >= lim);
    raw_pos  = !in_disparity_raw[DISP_W-1] && (in_disparity_raw != '0);
    dm       = {1'b0, in_map_x_here} - {1'b0, in_map_x_shifted};
    dm_pos   = !dm[MAP_W] && (dm[MAP_W-1:0] != '0);
    ok_nxt   = (focal_x_r != '0) && (focal_y_r != '0) &&
               (mode_r ? (!fish_bad && dm_pos) : raw_pos);
    den_nxt  = mode_r ? dm[MAP_W-1:0] : FOCAL_W'(in_disparity_raw[DISP_W-2:0]);
    u        = mode_r ? UW'(in_map_x_here) : UW'({in_pixel_x, 8'b0});
    v        = mode_r ? UW'(in_map_y_here) : UW'({in_pixel_y, 8'b0});
    dx       = {1'b0, u} - {1'b0, UW'(center_x_r)};
    dy       = {1'b0, v} - {1'b0, UW'(center_y_r)};
    zs_nxt.ok   = ok_nxt;
    zs_nxt.sx   = dx[UW];
    zs_nxt.magx = dx[UW] ? (~dx[UW-1:0] + 1'b1) : dx[UW-1:0];
    zs_nxt.sy   = dy[UW];
    zs_nxt.magy = dy[UW] ? (~dy[UW-1:0] + 1'b1) : dy[UW-1:0];
    zs_nxt.rgb  = {in_color_red, in_color_green, in_color_blue};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs_r    <= zs_nxt;
      den_r   <= den_nxt;
      fish1_r <= mode_r;
    end
  end

  // depth division
  logic [ZQ_W-1:0] zdiv_num, zq;
  logic            zv;
  z_side_t         zs_out;

  assign zdiv_num = fish1_r ? num_r[NUM_W-1:8] : ZQ_W'(num_r[NUM_W-1:12]);

  dtp_divider #(.QW(ZQ_W), .DW(FOCAL_W), .SW($bits(z_side_t))) u_zdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_rem    ('0),
    .in_num    (zdiv_num),
    .in_den    (den_r),
    .in_side   (zs_r),
    .out_valid (zv),
    .out_quo   (zq),
    .out_side  (zs_out)
  );

  // partial products, sum, overflow check
  logic [PPW-1:0]     ppxh_r, ppxl_r, ppyh_r, ppyl_r;
  logic [COORD_W-1:0] zsat_m1_r, zsat_m2_r, zsat_c_r;
  logic [PW-1:0]      prx_r, pry_r, prx_c_r, pry_c_r;
  logic               ovfx_r, ovfy_r;
  logic               vm1_r, vm2_r, vc_r;
  z_side_t            sm1_r, sm2_r, sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vc_r  <= 1'b0;
    end else if (en) begin
      vm1_r <= zv;
      vm2_r <= vm1_r;
      vc_r  <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ppxh_r    <= PPW'(zq[ZQ_W-1:HW]) * PPW'(zs_out.magx);
      ppxl_r    <= PPW'(zq[HW-1:0]) * PPW'(zs_out.magx);
      ppyh_r    <= PPW'(zq[ZQ_W-1:HW]) * PPW'(zs_out.magy);
      ppyl_r    <= PPW'(zq[HW-1:0]) * PPW'(zs_out.magy);
      zsat_m1_r <= (zq > ZQ_W'(SAT_POS)) ? SAT_POS : zq[COORD_W-1:0];
      sm1_r     <= zs_out;

      prx_r     <= {ppxh_r, {HW{1'b0}}} + PW'(ppxl_r);
      pry_r     <= {ppyh_r, {HW{1'b0}}} + PW'(ppyl_r);
      zsat_m2_r <= zsat_m1_r;
      sm2_r     <= sm1_r;

      ovfx_r    <= prx_r >= PW'({focal_x_r, {COORD_W{1'b0}}});
      ovfy_r    <= pry_r >= PW'({focal_y_r, {COORD_W{1'b0}}});
      prx_c_r   <= prx_r;
      pry_c_r   <= pry_r;
      zsat_c_r  <= zsat_m2_r;
      sc_r      <= sm2_r;
    end
  end

  // coordinate divisions
  x_side_t            xs_in, xs_out;
  y_side_t            ys_in, ys_out;
  logic [COORD_W-1:0] qx, qy;
  logic               xv, yv;

  always_comb begin
    xs_in.ok  = sc_r.ok;
    xs_in.sx  = sc_r.sx;
    xs_in.ovf = ovfx_r;
    xs_in.z   = zsat_c_r;
    xs_in.rgb = sc_r.rgb;
    ys_in.sy  = sc_r.sy;
    ys_in.ovf = ovfy_r;
  end

  dtp_divider #(.QW(COORD_W), .DW(FOCAL_W), .SW($bits(x_side_t))) u_xdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vc_r),
    .in_rem    (prx_c_r[OW-1:COORD_W]),
    .in_num    (prx_c_r[COORD_W-1:0]),
    .in_den    (focal_x_r),
    .in_side   (xs_in),
    .out_valid (xv),
    .out_quo   (qx),
    .out_side  (xs_out)
  );

  dtp_divider #(.QW(COORD_W), .DW(FOCAL_W), .SW($bits(y_side_t))) u_ydiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vc_r),
    .in_rem    (pry_c_r[OW-1:COORD_W]),
    .in_num    (pry_c_r[COORD_W-1:0]),
    .in_den    (focal_y_r),
    .in_side   (ys_in),
    .out_valid (yv),
    .out_quo   (qy),
    .out_side  (ys_out)
  );

  // saturation, box test, output register
  logic signed [COORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [COORD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic                      keep;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [RGB_W-1:0]          out_rgb_r;

  function automatic logic [COORD_W-1:0] sat_coord(
    input logic sgn, input logic ovf, input logic [COORD_W-1:0] q
  );
    logic [COORD_W-1:0] r;
    if (sgn) begin
      r = (ovf || (q[COORD_W-1] && (q[COORD_W-2:0] != '0))) ? SAT_NEG : (~q + 1'b1);
    end else begin
      r = (ovf || q[COORD_W-1]) ? SAT_POS : q;
    end
    return r;
  endfunction

  always_comb begin
    lo_x  = box_low_r[COORD_W-1:0];
    lo_y  = box_low_r[2*COORD_W-1:COORD_W];
    lo_z  = box_low_r[3*COORD_W-1:2*COORD_W];
    hi_x  = box_high_r[COORD_W-1:0];
    hi_y  = box_high_r[2*COORD_W-1:COORD_W];
    hi_z  = box_high_r[3*COORD_W-1:2*COORD_W];
    x_nxt = sat_coord(xs_out.sx, xs_out.ovf, qx);
    y_nxt = sat_coord(ys_out.sy, ys_out.ovf, qy);
    z_nxt = xs_out.z;
    keep  = xv && yv && xs_out.ok &&
            (lo_x < x_nxt) && (x_nxt < hi_x) &&
            (lo_y < y_nxt) && (y_nxt < hi_y) &&
            (lo_z < z_nxt) && (z_nxt < hi_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= x_nxt;
      out_y_r   <= y_nxt;
      out_z_r   <= z_nxt;
      out_rgb_r <= xs_out.rgb;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_point_x   = out_x_r;
  assign out_point_y   = out_y_r;
  assign out_point_z   = out_z_r;
  assign out_color_rgb = out_rgb_r;

  a_rise_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(en))
    else $error("result appeared without pipe advance");

  a_x_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lo_x < out_point_x) && (out_point_x < hi_x))
    else $error("x outside box");

  a_y_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lo_y < out_point_y) && (out_point_y < hi_y))
    else $error("y outside box");

  a_z_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lo_z < out_point_z) && (out_point_z < hi_z))
    else $error("z outside box");

  a_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_point_z[COORD_W-1])
    else $error("negative depth");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives pixels through the disparity to point core in pinhole and fisheye
// modes. Each accepted pixel is run through a fixed-point projection in the
// testbench, and every point that stays inside the box is queued. Emitted
// points are checked in order, field by field. Registers are written over the
// APB port only while the core is empty. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam int PIX_W     = 12;
  localparam int PIPE_WAIT = 100;
  localparam int WDOG_MAX  = 4000;
  localparam logic [BOX_W-1:0] BOX_ALL_LOW  = {3{SAT_NEG}};
  localparam logic [BOX_W-1:0] BOX_ALL_HIGH = {3{SAT_POS}};

  typedef struct {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [DISP_W-1:0]  disp;
    logic [MAP_W-1:0]   mxh;
    logic [MAP_W-1:0]   mxs;
    logic [MAP_W-1:0]   myh;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [RGB_W-1:0]   rgb;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] in_pixel_x = '0;
  logic [PIX_W-1:0] in_pixel_y = '0;
  logic signed [DISP_W-1:0] in_disparity_raw = '0;
  logic [MAP_W-1:0] in_map_x_here = '0;
  logic [MAP_W-1:0] in_map_x_shifted = '0;
  logic [MAP_W-1:0] in_map_y_here = '0;
  logic [COLOR_W-1:0] in_color_blue = '0;
  logic [COLOR_W-1:0] in_color_green = '0;
  logic [COLOR_W-1:0] in_color_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [COORD_W-1:0] out_point_z;
  logic [RGB_W-1:0] out_color_rgb;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // register mirror
  logic               fisheye_on;
  logic [FOCAL_W-1:0] fx_q, fy_q, cx_q, cy_q;
  logic [BASE_W-1:0]  base_q;
  logic [BOX_W-1:0]   box_lo_q, box_hi_q;

  point_t pending_points[$];
  int     errors = 0;
  int     points_seen = 0;
  int     wdog = 0;
  int     hold_left = 0;
  bit     calm = 1'b0;

  disparity_to_point_core #(.PIXEL_INDEX_BITS(PIX_W)) u_dut (.*);

  always #5 clk = ~clk;

  function automatic longint clamp_coord(longint zfull, longint diff, longint f);
    longint unsigned mag;
    longint unsigned q;
    mag = diff < 0 ? -diff : diff;
    q = longint'(zfull) * mag / f;
    if (diff < 0) begin
      if (q > 1048576) q = 1048576;
      return -longint'(q);
    end
    if (q > 1048575) q = 1048575;
    return longint'(q);
  endfunction

  function automatic bit in_box(longint v, int sh);
    longint lo, hi;
    lo = longint'($signed(box_lo_q[sh +: COORD_W]));
    hi = longint'($signed(box_hi_q[sh +: COORD_W]));
    return lo < v && v < hi;
  endfunction

  function automatic bit project_pixel(input pixel_t p, output point_t r);
    longint raw, dm, num, zfull, u, v, x, y, z;
    raw = longint'($signed(p.disp));
    num = longint'(fx_q) * longint'(base_q);
    r = '{default: '0};
    if (fx_q == 0 || fy_q == 0) return 1'b0;
    if (fisheye_on) begin
      if (raw < 16 || raw >= longint'(p.px) * 16) return 1'b0;
      dm = longint'(p.mxh) - longint'(p.mxs);
      if (dm <= 0) return 1'b0;
      zfull = num / (dm * 256);
      u = p.mxh;
      v = p.myh;
    end else begin
      if (raw <= 0) return 1'b0;
      zfull = num / (raw * 4096);
      u = longint'(p.px) << 8;
      v = longint'(p.py) << 8;
    end
    z = zfull > 1048575 ? 1048575 : zfull;
    x = clamp_coord(zfull, u - longint'(cx_q), fx_q);
    y = clamp_coord(zfull, v - longint'(cy_q), fy_q);
    if (!(in_box(x, 0) && in_box(y, 21) && in_box(z, 42))) return 1'b0;
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.z = z[COORD_W-1:0];
    r.rgb = {p.red, p.green, p.blue};
    return 1'b1;
  endfunction

  task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DW-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_MODE:     fisheye_on = v[0];
      REG_FOCAL_X:  fx_q = v[FOCAL_W-1:0];
      REG_FOCAL_Y:  fy_q = v[FOCAL_W-1:0];
      REG_CENTER_X: cx_q = v[FOCAL_W-1:0];
      REG_CENTER_Y: cy_q = v[FOCAL_W-1:0];
      REG_BASELINE: base_q = v[BASE_W-1:0];
      REG_BOX_LOW:  box_lo_q = v[BOX_W-1:0];
      REG_BOX_HIGH: box_hi_q = v[BOX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t p);
    int gap;
    point_t pt;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= p.px;
    in_pixel_y <= p.py;
    in_disparity_raw <= p.disp;
    in_map_x_here <= p.mxh;
    in_map_x_shifted <= p.mxs;
    in_map_y_here <= p.myh;
    in_color_blue <= p.blue;
    in_color_green <= p.green;
    in_color_red <= p.red;
    do @(posedge clk); while (in_stall);
    if (project_pixel(p, pt)) pending_points = {pending_points, pt};
  endtask

  // idle the input and let the pipe empty before touching registers
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_points.size() > 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  function automatic pixel_t noise_pixel();
    pixel_t p;
    p.px = $urandom;
    p.py = $urandom;
    p.disp = $urandom;
    p.mxh = $urandom;
    p.mxs = $urandom;
    p.myh = $urandom;
    p.blue = $urandom;
    p.green = $urandom;
    p.red = $urandom;
    return p;
  endfunction

  function automatic pixel_t clean_pixel(bit fish);
    pixel_t p;
    int top, span;
    p = noise_pixel();
    if (fish) begin
      p.px = $urandom_range(2, 4095);
      top = p.px * 16 - 1;
      if ($urandom_range(0, 3) != 0 && top > 4000) top = 4000;
      p.disp = $urandom_range(16, top);
      p.mxh = $urandom_range(1, 1048575);
      span = p.mxh < 8192 ? p.mxh : 8192;
      p.mxs = p.mxh - $urandom_range(1, span);
    end else begin
      p.disp = $urandom_range(0, 7) == 0 ? $urandom_range(1, 32767) : $urandom_range(1, 2047);
    end
    return p;
  endfunction

  function automatic pixel_t mk_pixel(int px, int py, int d, int mxh, int mxs, int myh);
    pixel_t p;
    p.px = px;
    p.py = py;
    p.disp = d;
    p.mxh = mxh;
    p.mxs = mxs;
    p.myh = myh;
    p.blue = $urandom;
    p.green = $urandom;
    p.red = $urandom;
    return p;
  endfunction

  task automatic set_camera(bit fish, int f, int b, int c);
    cfg_write(REG_MODE, fish);
    cfg_write(REG_FOCAL_X, f);
    cfg_write(REG_FOCAL_Y, f);
    cfg_write(REG_CENTER_X, c);
    cfg_write(REG_CENTER_Y, c);
    cfg_write(REG_BASELINE, b);
    cfg_write(REG_BOX_LOW, BOX_ALL_LOW);
    cfg_write(REG_BOX_HIGH, BOX_ALL_HIGH);
  endtask

  task automatic test_reset_state();
    repeat (4) send_pixel(clean_pixel(1'b0));
    drain_pipe();
  endtask

  task automatic test_pinhole_directed();
    set_camera(1'b0, 256 << 8, 1 << 16, 2048 << 8);
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(100, 100, -1, 0, 0, 0));
    send_pixel(mk_pixel(100, 100, -32768, 0, 0, 0));
    send_pixel(mk_pixel(100, 100, 1, 0, 0, 0));
    send_pixel(mk_pixel(0, 0, 16, 0, 0, 0));
    send_pixel(mk_pixel(4095, 4095, 16, 0, 0, 0));
    send_pixel(mk_pixel(2048, 2048, 32767, 1048575, 0, 1048575));
    send_pixel(mk_pixel(300, 3000, 512, 0, 0, 0));
    drain_pipe();
  endtask

  task automatic test_fisheye_directed();
    set_camera(1'b1, 256 << 8, 1 << 16, 2048 << 8);
    send_pixel(mk_pixel(100, 0, 15, 5000, 1000, 5000));
    send_pixel(mk_pixel(100, 4095, 16, 600000, 599000, 400000));
    send_pixel(mk_pixel(100, 0, 1599, 600000, 598000, 400000));
    send_pixel(mk_pixel(100, 0, 1600, 600000, 598000, 400000));
    send_pixel(mk_pixel(0, 0, 16, 600000, 598000, 400000));
    send_pixel(mk_pixel(200, 0, 64, 700000, 700000, 1));
    send_pixel(mk_pixel(200, 0, 64, 700000, 700001, 1));
    send_pixel(mk_pixel(200, 0, 64, 1048575, 0, 1048575));
    send_pixel(mk_pixel(4095, 0, 32767, 1, 0, 0));
    drain_pipe();
  endtask

  task automatic test_zero_focal();
    cfg_write(REG_MODE, 1'b0);
    cfg_write(REG_FOCAL_X, 0);
    repeat (3) send_pixel(clean_pixel(1'b0));
    drain_pipe();
    cfg_write(REG_FOCAL_X, 256 << 8);
    cfg_write(REG_FOCAL_Y, 0);
    repeat (3) send_pixel(clean_pixel(1'b0));
    drain_pipe();
    cfg_write(REG_FOCAL_Y, 256 << 8);
  endtask

  task automatic test_box_bounds();
    cfg_write(REG_BOX_LOW, BOX_ALL_HIGH);
    cfg_write(REG_BOX_HIGH, BOX_ALL_HIGH);
    repeat (4) send_pixel(clean_pixel(1'b0));
    drain_pipe();
    cfg_write(REG_BOX_LOW, BOX_ALL_HIGH);
    cfg_write(REG_BOX_HIGH, BOX_ALL_LOW);
    repeat (4) send_pixel(clean_pixel(1'b0));
    drain_pipe();
    // tight box around z = 256.0, x and y within +-8
    cfg_write(REG_BOX_LOW, {21'd65535, -21'sd2048, -21'sd2048});
    cfg_write(REG_BOX_HIGH, {21'd65537, 21'sd2048, 21'sd2048});
    for (int i = 0; i < 6; i++)
      send_pixel(mk_pixel(2048 + i * 2 - 6, 2048 - i * 2 + 6, 16, 0, 0, 0));
    drain_pipe();
  endtask

  task automatic test_config_extremes();
    set_camera(1'b0, 1048575, 16777215, 1048575);
    repeat (40) send_pixel(clean_pixel(1'b0));
    drain_pipe();
    set_camera(1'b1, 1, 16777215, 0);
    repeat (40) send_pixel(clean_pixel(1'b1));
    drain_pipe();
  endtask

  task automatic test_random_traffic();
    bit fish;
    logic [BOX_W-1:0] lo, hi;
    for (int ph = 0; ph < 8; ph++) begin
      fish = ph[0];
      calm = (ph == 2 || ph == 5);
      set_camera(fish, $urandom_range(16 << 8, 2048 << 8), $urandom_range(1, 1 << 20),
                 $urandom_range(0, 4095 << 8));
      if (ph == 6) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        cfg_write(REG_BOX_LOW, lo);
        cfg_write(REG_BOX_HIGH, hi);
      end
      for (int i = 0; i < 240; i++) begin
        send_pixel($urandom_range(0, 4) == 0 ? noise_pixel() : clean_pixel(fish));
        if (ph == 3 && i == 120) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_points.size() > 0);
        end
      end
      drain_pipe();
    end
    calm = 1'b0;
  endtask

  // result side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
    end else if (out_valid && !out_stall) begin
      hold_left = calm ? 0 : $urandom_range(0, 9);
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= hold_left > 0;
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d z=%0d rgb=%06h", $time,
                 out_point_x, out_point_y, out_point_z, out_color_rgb);
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) begin
          errors++;
          $display("%0t: point_x expected %0d actual %0d", $time, $signed(want.x), out_point_x);
        end
        if (out_point_y !== want.y) begin
          errors++;
          $display("%0t: point_y expected %0d actual %0d", $time, $signed(want.y), out_point_y);
        end
        if (out_point_z !== want.z) begin
          errors++;
          $display("%0t: point_z expected %0d actual %0d", $time, $signed(want.z), out_point_z);
        end
        if (out_color_rgb !== want.rgb) begin
          errors++;
          $display("%0t: color_rgb expected %06h actual %06h", $time, want.rgb, out_color_rgb);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    fisheye_on = 1'b0;
    fx_q = FOCAL_RST;
    fy_q = FOCAL_RST;
    cx_q = '0;
    cy_q = '0;
    base_q = '0;
    box_lo_q = '0;
    box_hi_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_pinhole_directed();
    test_fisheye_directed();
    test_zero_focal();
    test_box_bounds();
    test_config_extremes();
    test_random_traffic();
    if (pending_points.size() > 0) begin
      errors++;
      $display("%0t: %0d points never emitted", $time, pending_points.size());
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
